// File: rtl/bdl_pkg.sv
// ----------------------------------------------------------------------------
// bdl_pkg
// shared constants, codes and types of the bounded deque list engine
// ----------------------------------------------------------------------------
`default_nettype none

package bdl_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  // operation codes of an input transaction
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_READ_FWD   = 3'd3;
  localparam logic [2:0] OP_READ_BWD   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // action broadcast to every cell of the chain
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_REMOVE,
    ACT_ROT_FWD,
    ACT_ROT_BWD
  } bdl_act_e;

  typedef struct packed {
    bdl_act_e            action;
    logic [DATA_W-1:0]   value;
  } bdl_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bdl_cell.sv
// ----------------------------------------------------------------------------
// bdl_cell
// one list slot: holds an entry and trades it with its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_cell (
  input  wire                           clk_i,
  input  wire  bdl_pkg::bdl_ctl_t       ctl_i,
  input  wire                           occupied_i,
  input  wire                           tail_i,
  input  wire                           at_end_i,
  input  wire  [bdl_pkg::DATA_W-1:0]    left_val_i,
  input  wire  [bdl_pkg::DATA_W-1:0]    right_val_i,
  input  wire  [bdl_pkg::DATA_W-1:0]    head_val_i,
  input  wire                           seen_i,
  output logic                          seen_o,
  output logic [bdl_pkg::DATA_W-1:0]    val_o
);
  import bdl_pkg::*;

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;
  logic              match;

  always_comb begin
    match  = occupied_i && (val_q == ctl_i.value);
    seen_o = seen_i | match;
    val_d  = val_q;
    case (ctl_i.action)
      ACT_PUSH_FRONT: val_d = left_val_i;
      ACT_PUSH_BACK: begin
        if (at_end_i) val_d = ctl_i.value;
      end
      ACT_REMOVE: begin
        // first match and everything behind it close the gap
        if (seen_o) val_d = right_val_i;
      end
      ACT_ROT_FWD: begin
        if (occupied_i) val_d = tail_i ? head_val_i : right_val_i;
      end
      ACT_ROT_BWD: begin
        if (occupied_i) val_d = left_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// File: rtl/bounded_deque_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_list_engine
// ordered list of signed 32-bit values with front/back insert, remove, read
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid_i / in_stall_o carries op_i and value_in_i
//   output channel out_valid_o / out_stall_i carries value_out_o, status_o,
//   last_o; a transaction moves when valid is high and stall is low
//   insert and remove give a registered result transaction, which shows up
//   on the cycle after the input transaction
//   a read of n entries gives one entry per cycle while the receiver does not
//   stall, since the entries leave by rotating the cell chain past the
//   head (forward) or the tail (backward); after n steps the chain is back
//   in its original order; last_o marks the final entry
//   a read of an empty list, an insert and a remove each give a single
//   result with last_o set; op codes five to seven give no result
//   a stalled receiver freezes the output register and the read rotation,
//   and holds off new input transactions
//   reset empties the list and drops any pending result; entry storage is
//   not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_list_engine (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [2:0]                        op_i,
  input  wire  signed [bdl_pkg::DATA_W-1:0] value_in_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [bdl_pkg::DATA_W-1:0] value_out_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);
  import bdl_pkg::*;

  // list length and read sequencer
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_busy_q, rd_busy_d;
  logic              rd_fwd_q, rd_fwd_d;
  logic [CNT_W-1:0]  rd_left_q, rd_left_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic [1:0]        out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              can_load;
  logic              in_accept;
  logic              full;
  logic              found;

  bdl_ctl_t          ctl;

  // cell chain wiring
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY:0] seen;
  logic [IDX_W-1:0]  tail_idx;
  logic [DATA_W-1:0] tail_val;
  logic [DATA_W-1:0] head_val;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = rd_busy_q || !can_load;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(CAPACITY));

  assign tail_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign tail_val = cell_val[tail_idx];
  assign head_val = cell_val[0];
  assign found    = seen[CAPACITY];
  assign seen[0]  = 1'b0;

  // action broadcast to the chain
  always_comb begin
    ctl.action = ACT_NONE;
    ctl.value  = value_in_i;
    if (rd_busy_q) begin
      if (can_load) ctl.action = rd_fwd_q ? ACT_ROT_FWD : ACT_ROT_BWD;
    end else if (in_accept) begin
      case (op_i)
        OP_PUSH_FRONT: ctl.action = full ? ACT_NONE : ACT_PUSH_FRONT;
        OP_PUSH_BACK:  ctl.action = full ? ACT_NONE : ACT_PUSH_BACK;
        OP_REMOVE:     ctl.action = ACT_REMOVE;
        default:       ctl.action = ACT_NONE;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    if (i == 0) begin : g_head
      // head takes the pushed value, or the tail value when rotating backward
      assign left_val = (ctl.action == ACT_ROT_BWD) ? tail_val : ctl.value;
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    bdl_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (CNT_W'(i) < cnt_q),
      .tail_i      (CNT_W'(i + 1) == cnt_q),
      .at_end_i    (CNT_W'(i) == cnt_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .head_val_i  (head_val),
      .seen_i      (seen[i]),
      .seen_o      (seen[i+1]),
      .val_o       (cell_val[i])
    );
  end

  // control and result
  always_comb begin
    cnt_d        = cnt_q;
    rd_busy_d    = rd_busy_q;
    rd_fwd_d     = rd_fwd_q;
    rd_left_d    = rd_left_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (rd_busy_q) begin
      if (can_load) begin
        // emit head (forward) or tail (backward), chain rotates this cycle
        out_valid_d  = 1'b1;
        out_value_d  = rd_fwd_q ? head_val : tail_val;
        out_status_d = ST_OK;
        out_last_d   = (rd_left_q == CNT_W'(1));
        rd_left_d    = rd_left_q - CNT_W'(1);
        if (rd_left_q == CNT_W'(1)) rd_busy_d = 1'b0;
      end
    end else if (in_accept) begin
      out_value_d = '0;
      out_last_d  = 1'b1;
      case (op_i)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_valid_d  = 1'b1;
          out_status_d = full ? ST_FULL : ST_OK;
          if (!full) cnt_d = cnt_q + CNT_W'(1);
        end
        OP_REMOVE: begin
          out_valid_d  = 1'b1;
          out_status_d = found ? ST_OK : ST_NOT_FOUND;
          if (found) cnt_d = cnt_q - CNT_W'(1);
        end
        default: begin
          if (op_i inside {OP_READ_FWD, OP_READ_BWD}) begin
            if (cnt_q == '0) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_EMPTY;
            end else begin
              rd_busy_d = 1'b1;
              rd_fwd_d  = (op_i == OP_READ_FWD);
              rd_left_d = cnt_q;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_busy_q   <= 1'b0;
      rd_fwd_q    <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_busy_q   <= rd_busy_d;
      rd_fwd_q    <= rd_fwd_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_busy_q |-> (rd_left_q != '0) && (rd_left_q <= cnt_q))
    else $error("read sequencer out of range");

  a_read_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rd_busy_q) |-> out_valid_q && out_last_q)
    else $error("read ended without a final entry");

  a_no_input_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_busy_q |-> (cnt_q == $past(cnt_q)) || $rose(rd_busy_q))
    else $error("list length changed during a read");

endmodule

`default_nettype wire
